### design/sbg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and register codes for the spectral bin gate
package sbg_pkg;

    localparam int MAX_BINS    = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int IDX_W       = $clog2(MAX_BINS);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int RAM_DEPTH   = 2 ** ADDR_W;
    localparam int CNT_W       = IDX_W + 1;
    localparam int OUT_INDEX_W = 10;

    localparam int FRAME_W     = 11;
    localparam int RATIO_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 15;
    localparam int RATIO_FRAC2 = 28;
    localparam int LEN_W       = (FRAME_W > CNT_W) ? FRAME_W : CNT_W;

    localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
    localparam int POW_W       = 2 * SAMPLE_BITS;
    localparam int RATIO_SQ_W  = 2 * RATIO_W;
    localparam int THR_W       = POW_W + RATIO_SQ_W;
    localparam int LHS_W       = POW_W + RATIO_FRAC2;
    localparam int CMP_W       = (LHS_W > THR_W) ? LHS_W : THR_W;
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
    localparam int RND_W       = PROD_W + 1;
    localparam int SHR_W       = RND_W - GAIN_FRAC;

    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [FRAME_W-1:0] FRAME_BINS_RST      = FRAME_W'(512);
    localparam logic [RATIO_W-1:0] THRESHOLD_RATIO_RST = RATIO_W'(1638);
    localparam logic [GAIN_W-1:0]  BELOW_GAIN_RST      = GAIN_W'(0);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t bin_real;
        sample_t bin_imag;
    } bin_in_t;

    typedef struct packed {
        sample_t                 out_real;
        sample_t                 out_imag;
        logic [OUT_INDEX_W-1:0]  out_index;
        logic                    frame_last;
        logic                    was_gated;
    } bin_out_t;

    typedef struct packed {
        sample_t re;
        sample_t im;
    } ram_word_t;

    typedef struct packed {
        logic accept;
        logic dc_bin;
        logic peak_update;
        logic frame_end;
    } dp_ctrl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_GATE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        REG_FRAME_BINS      = 2'd0,
        REG_THRESHOLD_RATIO = 2'd1,
        REG_BELOW_GAIN      = 2'd2
    } reg_index_t;

endpackage

### design/sbg_bin_ram.sv
`timescale 1ns / 1ps
// double-banked frame store, one write port and one registered read port
module sbg_bin_ram
    import sbg_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  ram_word_t         wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output ram_word_t         rdata
);

    ram_word_t mem [RAM_DEPTH];
    ram_word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/sbg_datapath.sv
`timescale 1ns / 1ps
// power, peak tracking, threshold compare and gain scaling
module sbg_datapath
    import sbg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_ctrl_t           ctrl,
    input  bin_in_t            in_bin,
    input  logic [RATIO_W-1:0] ratio,
    input  logic [GAIN_W-1:0]  gain,
    input  ram_word_t          rd_word,
    output ram_word_t          wr_word,
    output sample_t            out_re,
    output sample_t            out_im,
    output logic               gated
);

    function automatic sample_t round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [RND_W-1:0] sum;
        logic signed [SHR_W-1:0] shr;
        logic signed [SHR_W-1:0] smax;
        logic signed [SHR_W-1:0] smin;
        sample_t                 res;
        sum  = RND_W'(p) + RND_W'(1 << (GAIN_FRAC - 1));
        shr  = SHR_W'(sum >>> GAIN_FRAC);
        smax = SHR_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        smin = -smax - SHR_W'(1);
        if (shr > smax)
        begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else if (shr < smin)
        begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            res = SAMPLE_BITS'(shr);
        end
        return res;
    endfunction

    ram_word_t                  in_word_reg;
    logic [SQ_W-1:0]            in_re_sq_reg;
    logic [SQ_W-1:0]            in_im_sq_reg;
    logic [SQ_W-1:0]            st_re_sq_reg;
    logic [SQ_W-1:0]            st_im_sq_reg;
    logic [POW_W-1:0]           pw_reg;
    logic [POW_W-1:0]           spw_reg;
    logic [RATIO_SQ_W-1:0]      ratio_sq_reg;
    logic [THR_W-1:0]           thr_prod_reg;
    logic                       gated_reg;
    logic signed [PROD_W-1:0]   re_prod_reg;
    logic signed [PROD_W-1:0]   im_prod_reg;
    logic [POW_W-1:0]           cur_peak_reg;
    logic [POW_W-1:0]           prev_peak_reg;

    logic signed [POW_W-1:0]    in_re_sq_next;
    logic signed [POW_W-1:0]    in_im_sq_next;
    logic signed [POW_W-1:0]    st_re_sq_next;
    logic signed [POW_W-1:0]    st_im_sq_next;
    logic [THR_W-1:0]           thr_prod_next;
    logic [LHS_W-1:0]           lhs;
    logic                       gated_next;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]   re_prod_next;
    logic signed [PROD_W-1:0]   im_prod_next;

    always_comb
    begin
        wr_word.re = in_bin.bin_real;
        wr_word.im = ctrl.dc_bin ? sample_t'(0) : in_bin.bin_imag;
    end

    always_comb
    begin
        in_re_sq_next = in_word_reg.re * in_word_reg.re;
        in_im_sq_next = in_word_reg.im * in_word_reg.im;
        st_re_sq_next = rd_word.re * rd_word.re;
        st_im_sq_next = rd_word.im * rd_word.im;
        thr_prod_next = ratio_sq_reg * prev_peak_reg;
        lhs           = {spw_reg, {RATIO_FRAC2{1'b0}}};
        gated_next    = CMP_W'(lhs) < CMP_W'(thr_prod_reg);
        gain_s        = signed'({1'b0, gain});
        re_prod_next  = rd_word.re * gain_s;
        im_prod_next  = rd_word.im * gain_s;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            in_word_reg <= wr_word;
        end
        in_re_sq_reg <= in_re_sq_next[SQ_W-1:0];
        in_im_sq_reg <= in_im_sq_next[SQ_W-1:0];
        st_re_sq_reg <= st_re_sq_next[SQ_W-1:0];
        st_im_sq_reg <= st_im_sq_next[SQ_W-1:0];
        pw_reg       <= POW_W'(in_re_sq_reg) + POW_W'(in_im_sq_reg);
        spw_reg      <= POW_W'(st_re_sq_reg) + POW_W'(st_im_sq_reg);
        ratio_sq_reg <= ratio * ratio;
        thr_prod_reg <= thr_prod_next;
        gated_reg    <= gated_next;
        re_prod_reg  <= re_prod_next;
        im_prod_reg  <= im_prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_peak_reg  <= '0;
            prev_peak_reg <= '0;
        end
        else if (ctrl.frame_end)
        begin
            prev_peak_reg <= cur_peak_reg;
            cur_peak_reg  <= '0;
        end
        else if (ctrl.peak_update && (pw_reg > cur_peak_reg))
        begin
            cur_peak_reg <= pw_reg;
        end
    end

    always_comb
    begin
        gated  = gated_reg;
        out_re = gated_reg ? round_sat(re_prod_reg) : rd_word.re;
        out_im = gated_reg ? round_sat(im_prod_reg) : rd_word.im;
    end

endmodule

### design/spectral_bin_gate.sv
`timescale 1ns / 1ps
// spectral bin gate top level: config port, sequencer, frame store and output register
// Gates each complex bin against the peak power of its frame, one frame late: a bin
// goes into the current bank while the same index of the previous frame is read,
// compared against (threshold_ratio * peak magnitude) squared and scaled by
// below_gain when under it. The result is loaded into the output register after the
// transfer in, through frame store access, then squares and gain products, power
// sums, threshold compare, rounding and load; the next item is taken the cycle after
// that load, so no new item is taken while one is in flight; a full output
// register holds the item until out_ready. After reset the frame store is swept
// to zero, one entry per cycle; no bin is taken during the sweep, but register
// writes are.
module spectral_bin_gate
    import sbg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bin_in_t            in_bin,
    output logic               out_valid,
    input  logic               out_ready,
    output bin_out_t           out_bin,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    state_t               state_reg;
    state_t               state_next;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [IDX_W-1:0]     counter_reg;
    logic                 bank_reg;
    logic                 out_valid_reg;
    bin_out_t             out_bin_reg;
    logic [FRAME_W-1:0]   frame_bins_reg;
    logic [RATIO_W-1:0]   threshold_ratio_reg;
    logic [GAIN_W-1:0]    below_gain_reg;

    logic                 cfg_write;
    reg_index_t           reg_index;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    ram_word_t            ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    ram_word_t            ram_rdata;
    ram_word_t            wr_word;
    dp_ctrl_t             ctrl;
    logic                 load;
    logic                 last;
    logic [LEN_W-1:0]     len_raw;
    logic [LEN_W-1:0]     frame_len;
    sample_t              dp_re;
    sample_t              dp_im;
    logic                 dp_gated;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bins_reg      <= FRAME_BINS_RST;
            threshold_ratio_reg <= THRESHOLD_RATIO_RST;
            below_gain_reg      <= BELOW_GAIN_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_FRAME_BINS:      frame_bins_reg      <= pwdata[FRAME_W-1:0];
                REG_THRESHOLD_RATIO: threshold_ratio_reg <= pwdata[RATIO_W-1:0];
                REG_BELOW_GAIN:      below_gain_reg      <= pwdata[GAIN_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_FRAME_BINS:      prdata = PDATA_W'(frame_bins_reg);
            REG_THRESHOLD_RATIO: prdata = PDATA_W'(threshold_ratio_reg);
            REG_BELOW_GAIN:      prdata = PDATA_W'(below_gain_reg);
            default:             prdata = '0;
        endcase
    end

    // frame length, clamped to 1..MAX_BINS
    always_comb
    begin
        len_raw = LEN_W'(frame_bins_reg);
        if (len_raw == '0)
        begin
            frame_len = LEN_W'(1);
        end
        else if (len_raw > LEN_W'(MAX_BINS))
        begin
            frame_len = LEN_W'(MAX_BINS);
        end
        else
        begin
            frame_len = len_raw;
        end
        last = (LEN_W'(counter_reg) + LEN_W'(1)) >= frame_len;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        in_ready         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = {bank_reg, counter_reg};
        ram_wdata        = wr_word;
        ram_re           = 1'b0;
        ram_raddr        = {~bank_reg, counter_reg};
        load             = 1'b0;
        ctrl.accept      = 1'b0;
        ctrl.peak_update = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    ram_we      = 1'b1;
                    ram_re      = 1'b1;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_GATE;
            end
            ST_GATE:
            begin
                ctrl.peak_update = 1'b1;
                state_next       = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ctrl.dc_bin    = (counter_reg == '0);
        ctrl.frame_end = load && last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            counter_reg   <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (last)
                begin
                    bank_reg    <= ~bank_reg;
                    counter_reg <= '0;
                end
                else
                begin
                    counter_reg <= counter_reg + IDX_W'(1);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_bin_reg.out_real   <= dp_re;
            out_bin_reg.out_imag   <= dp_im;
            out_bin_reg.out_index  <= OUT_INDEX_W'(counter_reg);
            out_bin_reg.frame_last <= last;
            out_bin_reg.was_gated  <= dp_gated;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bin   = out_bin_reg;

    sbg_bin_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sbg_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .in_bin  (in_bin),
        .ratio   (threshold_ratio_reg),
        .gain    (below_gain_reg),
        .rd_word (ram_rdata),
        .wr_word (wr_word),
        .out_re  (dp_re),
        .out_im  (dp_im),
        .gated   (dp_gated)
    );

`ifndef SYNTHESIS
    a_no_input_during_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready
    ) else $error("input taken during frame store sweep");

    a_one_item_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("second item taken while one is in flight");

    a_bank_swap_on_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (load && last) |=> (bank_reg != $past(bank_reg)) && (counter_reg == '0)
    ) else $error("frame end did not swap banks");

    a_result_index: assert property (
        @(posedge clk) disable iff (!rst_n)
        load |=> out_valid && (out_bin.out_index == $past(OUT_INDEX_W'(counter_reg)))
    ) else $error("result index mismatch");
`endif

endmodule

### test/spectral_bin_gate_tb.sv
`timescale 1ns / 1ps
// testbench for the spectral bin gate: predicts each gated bin and checks every output transfer
module spectral_bin_gate_tb;
    import sbg_pkg::*;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    bin_in_t            in_bin    = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    bin_out_t           out_bin;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bin_in_t  bins_to_send[$];
    bin_out_t gated_bins_due[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;

    logic [FRAME_W-1:0] frame_len_cfg = FRAME_BINS_RST;
    logic [RATIO_W-1:0] ratio_cfg     = THRESHOLD_RATIO_RST;
    logic [GAIN_W-1:0]  gain_cfg      = BELOW_GAIN_RST;

    int              frame_re[2*MAX_BINS];
    int              frame_im[2*MAX_BINS];
    int              wr_bank   = 0;
    int              bin_pos   = 0;
    longint unsigned peak_now  = 0;
    longint unsigned peak_last = 0;

    spectral_bin_gate i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_bin    (in_bin),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_bin   (out_bin),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    function automatic int scale_part(int x);
        longint g;
        longint p;
        longint r;
        g = longint'(gain_cfg);
        p = x * g + 16384;
        r = p >>> GAIN_FRAC;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return int'(r);
    endfunction

    function automatic bin_out_t gate_next_bin(bin_in_t b);
        int              n;
        int              idx;
        int              re;
        int              im;
        int              sre;
        int              sim;
        int              wr_addr;
        int              rd_addr;
        longint unsigned pw;
        longint unsigned spw;
        longint unsigned q;
        logic            gated;
        bin_out_t        r;
        n = int'(frame_len_cfg);
        if (n < 1)
            n = 1;
        if (n > MAX_BINS)
            n = MAX_BINS;
        idx = bin_pos;
        re = int'(b.bin_real);
        im = (idx == 0) ? 0 : int'(b.bin_imag);
        wr_addr = wr_bank * MAX_BINS + idx;
        rd_addr = (1 - wr_bank) * MAX_BINS + idx;
        sre = frame_re[rd_addr];
        sim = frame_im[rd_addr];
        frame_re[wr_addr] = re;
        frame_im[wr_addr] = im;
        pw = longint'(re) * re + longint'(im) * im;
        if (pw > peak_now)
            peak_now = pw;
        spw = longint'(sre) * sre + longint'(sim) * sim;
        q = 64'(ratio_cfg);
        gated = (spw << RATIO_FRAC2) < (q * q * peak_last);
        r.out_real   = sample_t'(gated ? scale_part(sre) : sre);
        r.out_imag   = (idx == 0) ? '0 : sample_t'(gated ? scale_part(sim) : sim);
        r.out_index  = OUT_INDEX_W'(idx);
        r.frame_last = (idx + 1 >= n);
        r.was_gated  = gated;
        if (r.frame_last)
        begin
            wr_bank   = 1 - wr_bank;
            peak_last = peak_now;
            peak_now  = 0;
            bin_pos   = 0;
        end
        else
        begin
            bin_pos = idx + 1;
        end
        return r;
    endfunction

    function automatic sample_t random_part();
        sample_t v;
        case ($urandom_range(0, 11))
            0: v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            1: v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            2: v = '0;
            3: v = '1;
            default:
            begin
                v = sample_t'($urandom);
                v = v >>> $urandom_range(0, SAMPLE_BITS - 1);
            end
        endcase
        return v;
    endfunction

    task automatic check_gated_bin(bin_out_t got);
        bin_out_t want;
        if (gated_bins_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: re %0d im %0d idx %0d last %0b gated %0b",
                         got.out_real, got.out_imag, got.out_index, got.frame_last,
                         got.was_gated);
        end
        else
        begin
            want = gated_bins_due.pop_front();
            if (got.out_real !== want.out_real || got.out_imag !== want.out_imag ||
                got.out_index !== want.out_index || got.frame_last !== want.frame_last ||
                got.was_gated !== want.was_gated)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected re %0d im %0d idx %0d last %0b gated %0b",
                             want.out_real, want.out_imag, want.out_index,
                             want.frame_last, want.was_gated);
                    $display("          got      re %0d im %0d idx %0d last %0b gated %0b",
                             got.out_real, got.out_imag, got.out_index,
                             got.frame_last, got.was_gated);
                end
            end
        end
    endtask

    task automatic write_reg(reg_index_t r, logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(r));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_FRAME_BINS:      frame_len_cfg = value[FRAME_W-1:0];
            REG_THRESHOLD_RATIO: ratio_cfg     = value[RATIO_W-1:0];
            REG_BELOW_GAIN:      gain_cfg      = value[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (bins_to_send.size() != 0 || in_valid || gated_bins_due.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                gated_bins_due.push_back(gate_next_bin(in_bin));
            if (!in_valid || in_ready)
            begin
                if (bins_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_bin   <= bins_to_send.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_gated_bin(out_bin);
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        int      dir_re[16];
        int      dir_im[16];
        int      frame_sizes[12];
        int      phase_items[12];
        int      ph;
        int      k;
        bin_in_t b;
        logic [RATIO_W-1:0] ratio_val;
        logic [GAIN_W-1:0]  gain_val;
        dir_re = '{32767, -32768, 0, 1, -32768, 100, 32767, -1,
                   -32768, 32767, 20000, 1, 0, 0, 0, 0};
        dir_im = '{-32768, -32768, 0, -1, 32767, -100, 32767, 0,
                   0, -32768, -20000, 1, 0, 0, 0, 0};
        frame_sizes = '{1, 0, 2, 7, 16, 33, 1024, 5, 2047, 64, 3, 12};
        phase_items = '{60, 60, 70, 80, 80, 90, 1040, 80, 90, 130, 60, 90};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // short frames with extreme bins, then a gain above unity to hit saturation
        write_reg(REG_FRAME_BINS, 4);
        write_reg(REG_THRESHOLD_RATIO, 16384);
        write_reg(REG_BELOW_GAIN, 16384);
        for (k = 0; k < 12; k++)
        begin
            b.bin_real = sample_t'(dir_re[k]);
            b.bin_imag = sample_t'(dir_im[k]);
            bins_to_send.push_back(b);
        end
        wait_idle();
        write_reg(REG_THRESHOLD_RATIO, 65535);
        write_reg(REG_BELOW_GAIN, 65535);
        for (k = 12; k < 16; k++)
        begin
            b.bin_real = sample_t'(dir_re[k]);
            b.bin_imag = sample_t'(dir_im[k]);
            bins_to_send.push_back(b);
        end

        for (ph = 0; ph < 12; ph++)
        begin
            wait_idle();
            if (ph == 0)
                ratio_val = '0;
            else if (ph == 1)
                ratio_val = '1;
            else if (ph % 3 == 0)
                ratio_val = RATIO_W'($urandom_range(0, 65535));
            else
                ratio_val = RATIO_W'($urandom_range(200, 20000));
            if (ph == 1)
                gain_val = '0;
            else if (ph == 3)
                gain_val = GAIN_W'(32768);
            else if (ph == 5)
                gain_val = '1;
            else if (ph % 2 == 0)
                gain_val = GAIN_W'($urandom_range(0, 32768));
            else
                gain_val = GAIN_W'($urandom_range(0, 65535));
            write_reg(REG_FRAME_BINS, frame_sizes[ph]);
            write_reg(REG_THRESHOLD_RATIO, PDATA_W'(ratio_val));
            write_reg(REG_BELOW_GAIN, PDATA_W'(gain_val));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (k = 0; k < phase_items[ph]; k++)
            begin
                b.bin_real = random_part();
                b.bin_imag = random_part();
                bins_to_send.push_back(b);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("spectral_bin_gate_tb: clean");
        else
            $display("spectral_bin_gate_tb: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("spectral_bin_gate_tb: errors");
        $finish;
    end

endmodule
